FILE: hdl/psrb_pkg.sv
// Shared types and codes of the packet slot ring buffer.
package psrb_pkg;

    // Command carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_SPARE  = 2'd3
    } t_cmd;

    // Result status; the first three codes also serve as the write reject state.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DROP    = 2'd2,
        ST_NODATA  = 2'd3
    } t_status;

    // Control states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    localparam int CNT_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int M_TDATA_W = 112;

endpackage

FILE: hdl/psrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module psrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/packet_slot_ring_buffer.sv
// Top level of the packet slot ring buffer.
//
// A ring of SLOTS packet slots, each holding up to SLOT_BYTES bytes. The slave
// stream carries one command per beat: tuser is the command (write byte, read
// byte, status), tdata the byte to write and tlast the end of the packet being
// written. Every command beat yields exactly one master beat: tuser is the
// status, tlast marks the last byte of a packet read out, and tdata holds the
// byte read, the full and empty flags and the received, sent and dropped counts.
// A write or status beat finishes as it is taken when the output register is
// free; a read beat first waits for the registered read of the packet and
// length memories. Throughput: one write or status beat per cycle while the
// receiver does not stall. The block works on one beat at a time.
// Results sit in an output register, so a new beat is taken while the previous
// result waits; when the receiver stalls, the next beat waits inside the block
// and the slave side stops taking beats. Reset clears the slot occupancy flags,
// the indices and the counters at once, with no clearing pass; packet bytes
// and lengths live in memories whose contents are used only once written. The
// slave side takes no beats while reset is held.
module packet_slot_ring_buffer
    import psrb_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Slave side.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]           i_s_tuser,   // [1:0] cmd
    input  logic                 i_s_tlast,   // last_byte
    // Master side.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] byte_out, [8] full_res, [9] empty_res, [41:10] received_count,
    // [73:42] sent_count, [105:74] dropped_count, [111:106] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]           o_m_tuser,   // [1:0] status
    output logic                 o_m_tlast    // byte_out_last
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int ROFF_W = $clog2(SLOT_BYTES);
    localparam int DEPTH  = SLOTS * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAD_W  = M_TDATA_W - (BYTE_W + 2 + 3 * CNT_W);

    // Control and state registers.
    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_occ, n_occ;
    logic [SLOT_W-1:0]   r_wslot, n_wslot;
    logic [SLOT_W-1:0]   r_rslot, n_rslot;
    logic [LEN_W-1:0]    r_woff, n_woff;
    logic [ROFF_W-1:0]   r_roff, n_roff;
    t_status             r_rej, n_rej;
    logic [CNT_W-1:0]    r_rx, n_rx;
    logic [CNT_W-1:0]    r_tx, n_tx;
    logic [CNT_W-1:0]    r_drop, n_drop;

    // Held command beat.
    t_cmd                r_cmd;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;

    // Output register.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic                r_out_full;
    logic                r_out_empty;
    logic [CNT_W-1:0]    r_out_rx;
    logic [CNT_W-1:0]    r_out_tx;
    logic [CNT_W-1:0]    r_out_drop;

    // Combinational signals.
    logic                s_fire;
    logic                out_free;
    t_cmd                c_cmd;
    logic [BYTE_W-1:0]   c_byte;
    logic                c_last;
    logic                c_finish;
    t_status             c_status;
    logic [BYTE_W-1:0]   c_obyte;
    logic                c_olast;
    t_status             c_rej;
    logic [LEN_W-1:0]    c_woff_inc;
    logic                c_rd_done_last;

    // Memory ports.
    logic                byte_we;
    logic [ADDR_W-1:0]   byte_waddr;
    logic                byte_re;
    logic [ADDR_W-1:0]   byte_raddr;
    logic [BYTE_W-1:0]   byte_rdata;
    logic                len_we;
    logic [LEN_W-1:0]    len_rdata;

    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = i_rst_n && (r_state == S_IDLE);

    // The beat being worked on: the incoming one in idle, else the held one.
    assign c_cmd  = (r_state == S_IDLE) ? t_cmd'(i_s_tuser) : r_cmd;
    assign c_byte = (r_state == S_IDLE) ? i_s_tdata : r_byte;
    assign c_last = (r_state == S_IDLE) ? i_s_tlast : r_last;

    // A read always waits for the registered memory data; other beats finish
    // at once when the output register is free.
    assign c_finish = out_free &&
                      ((r_state == S_WORK) || (s_fire && c_cmd != CMD_READ));

    // Read issue happens when a read beat is taken.
    assign byte_re    = s_fire && (t_cmd'(i_s_tuser) == CMD_READ);
    assign byte_raddr = ADDR_W'(r_rslot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(r_roff);
    assign byte_waddr = ADDR_W'(r_wslot) * ADDR_W'(SLOT_BYTES)
                        + ADDR_W'(r_woff[ROFF_W-1:0]);

    // Write-side reject decision and offset step.
    always_comb begin
        c_rej      = r_rej;
        c_woff_inc = r_woff;
        if (r_woff == '0 && r_rej == ST_OK && r_occ[r_wslot]) begin
            c_rej = ST_DROP;
        end
        if (r_woff >= LEN_W'(SLOT_BYTES)) begin
            c_rej = ST_INVALID;
        end else begin
            c_woff_inc = r_woff + LEN_W'(1);
        end
    end

    // Finish logic: state update and result for the current beat.
    always_comb begin
        n_state        = r_state;
        n_occ          = r_occ;
        n_wslot        = r_wslot;
        n_rslot        = r_rslot;
        n_woff         = r_woff;
        n_roff         = r_roff;
        n_rej          = r_rej;
        n_rx           = r_rx;
        n_tx           = r_tx;
        n_drop         = r_drop;
        c_status       = ST_OK;
        c_obyte        = '0;
        c_olast        = 1'b0;
        byte_we        = 1'b0;
        len_we         = 1'b0;
        c_rd_done_last = 1'b0;

        if (s_fire && !c_finish) begin
            n_state = S_WORK;
        end else if (c_finish) begin
            n_state = S_IDLE;
        end

        if (c_finish) begin
            case (c_cmd)
                CMD_WRITE: begin
                    c_status = c_rej;
                    byte_we  = (c_rej == ST_OK) && (r_woff < LEN_W'(SLOT_BYTES));
                    if (c_last) begin
                        if (c_rej == ST_OK) begin
                            len_we         = 1'b1;
                            n_occ[r_wslot] = 1'b1;
                            n_wslot = (r_wslot == SLOT_W'(SLOTS - 1)) ? '0
                                      : r_wslot + SLOT_W'(1);
                            n_rx    = r_rx + CNT_W'(1);
                        end else if (c_rej == ST_DROP) begin
                            n_drop = r_drop + CNT_W'(1);
                        end
                        n_woff = '0;
                        n_rej  = ST_OK;
                    end else begin
                        n_woff = c_woff_inc;
                        n_rej  = c_rej;
                    end
                end
                CMD_READ: begin
                    if (!r_occ[r_rslot]) begin
                        c_status = ST_NODATA;
                    end else begin
                        c_obyte = byte_rdata;
                        if (LEN_W'(r_roff) + LEN_W'(1) >= len_rdata) begin
                            c_olast        = 1'b1;
                            c_rd_done_last = 1'b1;
                            n_occ[r_rslot] = 1'b0;
                            n_rslot = (r_rslot == SLOT_W'(SLOTS - 1)) ? '0
                                      : r_rslot + SLOT_W'(1);
                            n_roff  = '0;
                            n_tx    = r_tx + CNT_W'(1);
                        end else begin
                            n_roff = r_roff + ROFF_W'(1);
                        end
                    end
                end
                default: begin
                    c_status = ST_OK;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_woff      <= '0;
            r_roff      <= '0;
            r_rej       <= ST_OK;
            r_rx        <= '0;
            r_tx        <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_woff  <= n_woff;
            r_roff  <= n_roff;
            r_rej   <= n_rej;
            r_rx    <= n_rx;
            r_tx    <= n_tx;
            r_drop  <= n_drop;
            if (c_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held beat and result payload.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_byte <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (c_finish) begin
            r_out_status <= c_status;
            r_out_byte   <= c_obyte;
            r_out_last   <= c_olast;
            r_out_full   <= n_occ[n_wslot];
            r_out_empty  <= !n_occ[n_rslot];
            r_out_rx     <= n_rx;
            r_out_tx     <= n_tx;
            r_out_drop   <= n_drop;
        end
    end

    // Packet byte store.
    psrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (c_byte),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    // Packet length store, written at the last byte of a stored packet.
    psrb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_wslot),
        .i_wdata (c_woff_inc),
        .i_re    (byte_re),
        .i_raddr (r_rslot),
        .o_rdata (len_rdata)
    );

    // Master side outputs.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_drop, r_out_tx, r_out_rx,
                         r_out_empty, r_out_full, r_out_byte};

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !c_finish)
        else $error("result finished while output register was held");

    // Reading the last byte of a packet counts it as sent.
    a_sent_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_rd_done_last |=> (r_tx == $past(r_tx) + CNT_W'(1)))
        else $error("sent count did not advance at end of packet");

    // The end of a written packet always resets the write-side packet state.
    a_write_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_finish && c_cmd == CMD_WRITE && c_last) |=>
        (r_woff == '0 && r_rej == ST_OK))
        else $error("write offset or reject state kept after last byte");

    // At most one slot changes occupancy per cycle.
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_occ ^ n_occ) <= 1)
        else $error("more than one slot changed occupancy");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the packet slot ring buffer.
module tb
    import psrb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 8;
    localparam int SLOT_BYTES   = 2048;
    localparam int STALL_PCT    = 22;
    localparam int HANG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // One result beat as the block reports it.
    typedef struct packed {
        t_status     status;
        logic [7:0]  byte_out;
        logic        byte_last;
        logic        full;
        logic        empty;
        logic [31:0] rx_count;
        logic [31:0] tx_count;
        logic [31:0] drop_count;
    } t_ring_result;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata  = '0;   // [7:0] data_byte
    logic [1:0]           i_s_tuser  = '0;   // [1:0] cmd
    logic                 i_s_tlast  = 1'b0; // last_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [7:0] byte_out, [8] full_res, [9] empty_res, [41:10] received_count,
    // [73:42] sent_count, [105:74] dropped_count, [111:106] zero
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]           o_m_tuser;         // [1:0] status
    logic                 o_m_tlast;         // byte_out_last

    // Shadow copy of the ring.
    logic [7:0]  shadow_bytes [SLOTS*SLOT_BYTES];
    int          shadow_len [SLOTS];
    int          wr_slot;
    int          rd_slot;
    int          wr_offset;
    int          rd_offset;
    t_status     wr_reject;
    logic [31:0] rx_total;
    logic [31:0] tx_total;
    logic [31:0] drop_total;

    t_ring_result pending_results[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           stalls_on = 1'b1;
    int           packet_left = 0;

    packet_slot_ring_buffer #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Computes the result of one command beat and updates the shadow ring.
    function automatic t_ring_result ring_step(t_cmd cmd, logic [7:0] data, logic last);
        t_ring_result r;
        r.status    = ST_OK;
        r.byte_out  = '0;
        r.byte_last = 1'b0;
        case (cmd)
            CMD_WRITE: begin
                // The occupancy check is made once, at the first byte.
                if (wr_offset == 0 && wr_reject == ST_OK && shadow_len[wr_slot] != 0) begin
                    wr_reject = ST_DROP;
                end
                if (wr_offset >= SLOT_BYTES) begin
                    wr_reject = ST_INVALID;
                end else begin
                    if (wr_reject == ST_OK) begin
                        shadow_bytes[wr_slot*SLOT_BYTES + wr_offset] = data;
                    end
                    wr_offset++;
                end
                r.status = wr_reject;
                if (last) begin
                    if (wr_reject == ST_OK) begin
                        shadow_len[wr_slot] = wr_offset;
                        wr_slot = (wr_slot + 1) % SLOTS;
                        rx_total++;
                    end else if (wr_reject == ST_DROP) begin
                        drop_total++;
                    end
                    wr_offset = 0;
                    wr_reject = ST_OK;
                end
            end
            CMD_READ: begin
                if (shadow_len[rd_slot] == 0) begin
                    r.status = ST_NODATA;
                end else begin
                    if (rd_offset >= shadow_len[rd_slot]) begin
                        rd_offset = 0;
                    end
                    r.byte_out = shadow_bytes[rd_slot*SLOT_BYTES + rd_offset];
                    if (rd_offset + 1 >= shadow_len[rd_slot]) begin
                        r.byte_last = 1'b1;
                        shadow_len[rd_slot] = 0;
                        rd_slot = (rd_slot + 1) % SLOTS;
                        rd_offset = 0;
                        tx_total++;
                    end else begin
                        rd_offset++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.full       = (shadow_len[wr_slot] != 0);
        r.empty      = (shadow_len[rd_slot] == 0);
        r.rx_count   = rx_total;
        r.tx_count   = tx_total;
        r.drop_count = drop_total;
        return r;
    endfunction

    // Sends one command beat, with an optional random gap before it.
    task automatic send_item(t_cmd cmd, logic [7:0] data, logic last);
        if (stalls_on && $urandom_range(99) < STALL_PCT) begin
            i_s_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < STALL_PCT);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= cmd;
        i_s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        pending_results.push_back(ring_step(cmd, data, last));
    endtask

    task automatic write_packet(int len);
        for (int i = 0; i < len; i++) begin
            send_item(CMD_WRITE, 8'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic read_bytes(int count);
        for (int i = 0; i < count; i++) begin
            send_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Receiver: random back-pressure unless stalls are switched off.
    always @(posedge i_clk) begin
        i_m_tready <= !stalls_on || ($urandom_range(99) >= STALL_PCT);
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_ring_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_m_tuser);
                check_field("byte_out", want.byte_out, o_m_tdata[7:0]);
                check_field("byte_out_last", want.byte_last, o_m_tlast);
                check_field("full_res", want.full, o_m_tdata[8]);
                check_field("empty_res", want.empty, o_m_tdata[9]);
                check_field("received_count", want.rx_count, o_m_tdata[41:10]);
                check_field("sent_count", want.tx_count, o_m_tdata[73:42]);
                check_field("dropped_count", want.drop_count, o_m_tdata[105:74]);
            end
        end
    end

    // Watchdog on cycles without any beat on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Status-only commands, the spare code and a read of the empty ring.
    task automatic test_status_and_empty();
        send_item(CMD_STATUS, 8'hFF, 1'b1);
        send_item(CMD_SPARE, 8'h00, 1'b0);
        send_item(CMD_READ, 8'hA5, 1'b1);
    endtask

    // One-byte packets carrying the extreme byte values.
    task automatic test_single_byte_packets();
        send_item(CMD_WRITE, 8'h00, 1'b1);
        send_item(CMD_READ, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'hFF, 1'b1);
        send_item(CMD_READ, 8'hFF, 1'b1);
    endtask

    // Fill every slot, lose a packet to the full ring, then drain it.
    task automatic test_fill_and_drop();
        for (int i = 0; i < SLOTS; i++) begin
            write_packet(1);
        end
        write_packet(3);
        send_item(CMD_STATUS, 8'h5A, 1'b0);
        read_bytes(SLOTS + 1);
    endtask

    // One byte too long on a full ring: the length error outranks the drop.
    task automatic test_long_packets();
        for (int i = 0; i < SLOTS; i++) begin
            write_packet(1);
        end
        write_packet(SLOT_BYTES + 1);
        read_bytes(SLOTS + 1);
    endtask

    // Interleaved packet writes, reads and status beats with shifting balance.
    task automatic test_random_traffic(int items, bit with_stalls);
        int write_pct;
        write_pct = 50;
        stalls_on = with_stalls;
        for (int i = 0; i < items; i++) begin
            // Every so often tilt toward filling or draining the ring.
            if (i % 100 == 0) begin
                case ($urandom_range(2))
                    0: write_pct = 25;
                    1: write_pct = 50;
                    default: write_pct = 80;
                endcase
            end
            if ($urandom_range(99) < 5) begin
                send_item($urandom_range(1) ? CMD_STATUS : CMD_SPARE,
                          8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if ($urandom_range(99) < write_pct) begin
                if (packet_left == 0) begin
                    packet_left = ($urandom_range(99) < 2) ? $urandom_range(64, 300)
                                                           : $urandom_range(1, 12);
                end
                send_item(CMD_WRITE, 8'($urandom_range(255)), packet_left == 1);
                packet_left--;
            end else begin
                read_bytes(1);
            end
        end
        stalls_on = 1'b1;
    endtask

    initial begin
        rx_total   = '0;
        tx_total   = '0;
        drop_total = '0;
        wr_slot    = 0;
        rd_slot    = 0;
        wr_offset  = 0;
        rd_offset  = 0;
        wr_reject  = ST_OK;
        foreach (shadow_len[i]) begin
            shadow_len[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_and_empty();
        test_single_byte_packets();
        test_fill_and_drop();
        test_long_packets();
        test_random_traffic(150, 1'b1);
        test_random_traffic(100, 1'b0);
        test_random_traffic(100, 1'b1);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: packet_slot_ring_buffer.f
hdl/psrb_pkg.sv
hdl/psrb_ram.sv
hdl/packet_slot_ring_buffer.sv
tb/tb.sv
